### sv/tle_pkg.sv
// Shared types and constants for the terminal line editor.
// Depends on nothing; used by tle_ctrl, tle_datapath and the top level.
`default_nettype none

package tle_pkg;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_ECHO    = 3'd0,
        ACT_BELL    = 3'd1,
        ACT_ERASE   = 3'd2,
        ACT_NEWLINE = 3'd3,
        ACT_READ    = 3'd4,
        ACT_EMPTY   = 3'd5,
        ACT_REJECT  = 3'd6
    } action_t;

    // Control characters
    localparam logic [7:0] CHR_BS   = 8'h08;
    localparam logic [7:0] CHR_DEL  = 8'h7F;
    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_BEL  = 8'h07;
    localparam logic [7:0] CHR_ETB  = 8'h17;  // Ctrl-W
    localparam logic [7:0] CHR_NAK  = 8'h15;  // Ctrl-U
    localparam logic [7:0] CHR_TAB  = 8'h09;
    localparam logic [7:0] CHR_SP   = 8'h20;

    localparam logic KIND_EDIT = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_WORD,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        CLS_CR,
        CLS_ERASE1,
        CLS_WERASE,
        CLS_KILL,
        CLS_OTHER
    } byte_class_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_POP,
        DP_PUSH_NL,
        DP_PUSH_BYTE,
        DP_DROP,
        DP_CLEAR,
        DP_WORD_DROP
    } dp_op_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL_PREV,
        RD_TAIL_PREV2
    } rd_sel_t;

    typedef struct packed {
        logic    latch_in;
        dp_op_t  op;
        rd_sel_t rd_sel;
        logic    rd_en;
        logic    res_load;
        action_t res_action;
        logic    clr_n;
        logic    out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic        kind;
        byte_class_t cls;
        logic        ready;
        logic        held_zero;
        logic        held_one;
        logic        full;
        logic        rd_white;
        logic        n_zero;
        logic        out_free;
    } dp_status_t;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CHR_SP) || ((c >= CHR_TAB) && (c <= CHR_CR));
    endfunction

endpackage

`default_nettype wire

### sv/tle_datapath.sv
// Datapath of the line editor: ring memory, indexes, counters, result and
// output registers. Uses tle_pkg; driven by tle_ctrl commands.
`default_nettype none

module tle_datapath #(
    parameter int RING_DEPTH = 127
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_kind,
    input  wire  [7:0]            in_byte,
    input  wire                   m_tready,
    input  tle_pkg::ctl_cmd_t     cmd,
    output tle_pkg::dp_status_t   status,
    output logic                  out_valid,
    output tle_pkg::action_t      out_action,
    output logic [7:0]            out_byte,
    output logic [6:0]            out_count,
    output logic                  out_last
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(RING_DEPTH - 1);

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    logic [7:0] mem [RING_DEPTH];

    logic                kind_reg;
    logic [7:0]          byte_reg;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       held_reg, held_next;
    logic [CW-1:0]       n_reg, n_next;
    logic                ready_reg, ready_next;
    logic [7:0]          rd_data_reg;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [7:0]          wr_data;

    tle_pkg::action_t    res_action_reg;
    logic [7:0]          res_byte_reg, res_byte_next;
    logic                res_last_reg;

    logic                out_valid_reg;
    tle_pkg::action_t    out_action_reg;
    logic [7:0]          out_byte_reg;
    logic [6:0]          out_count_reg;
    logic                out_last_reg;

    // input latch
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg <= in_kind;
            byte_reg <= in_byte;
        end
    end

    // ring memory, registered read
    always_comb
    begin
        unique case (cmd.rd_sel)
            tle_pkg::RD_HEAD:       rd_addr = head_reg;
            tle_pkg::RD_TAIL_PREV:  rd_addr = ring_prev(tail_reg);
            tle_pkg::RD_TAIL_PREV2: rd_addr = ring_prev(ring_prev(tail_reg));
            default:                rd_addr = head_reg;
        endcase
    end

    assign wr_en   = (cmd.op == tle_pkg::DP_PUSH_NL) || (cmd.op == tle_pkg::DP_PUSH_BYTE);
    assign wr_data = (cmd.op == tle_pkg::DP_PUSH_NL) ? tle_pkg::CHR_LF : byte_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // index and count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        held_next  = held_reg;
        ready_next = ready_reg;
        n_next     = cmd.clr_n ? '0 : n_reg;
        unique case (cmd.op)
            tle_pkg::DP_NONE:
            begin
            end
            tle_pkg::DP_POP:
            begin
                head_next = ring_next(head_reg);
                held_next = held_reg - 1'b1;
                if (status.held_one)
                begin
                    ready_next = 1'b0;
                end
            end
            tle_pkg::DP_PUSH_NL:
            begin
                tail_next  = ring_next(tail_reg);
                held_next  = held_reg + 1'b1;
                ready_next = 1'b1;
            end
            tle_pkg::DP_PUSH_BYTE:
            begin
                tail_next = ring_next(tail_reg);
                held_next = held_reg + 1'b1;
            end
            tle_pkg::DP_DROP:
            begin
                tail_next = ring_prev(tail_reg);
                held_next = held_reg - 1'b1;
                n_next    = CW'(1);
            end
            tle_pkg::DP_CLEAR:
            begin
                // tail = head + held around the ring, so a full kill lands on head
                tail_next = head_reg;
                held_next = '0;
                n_next    = held_reg;
            end
            tle_pkg::DP_WORD_DROP:
            begin
                tail_next = ring_prev(tail_reg);
                held_next = held_reg - 1'b1;
                n_next    = n_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            held_reg  <= '0;
            ready_reg <= 1'b0;
            n_reg     <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            held_reg  <= held_next;
            ready_reg <= ready_next;
            n_reg     <= n_next;
        end
    end

    // pending result
    always_comb
    begin
        unique case (cmd.res_action)
            tle_pkg::ACT_ECHO,
            tle_pkg::ACT_REJECT: res_byte_next = byte_reg;
            tle_pkg::ACT_BELL:   res_byte_next = tle_pkg::CHR_BEL;
            tle_pkg::ACT_READ:   res_byte_next = rd_data_reg;
            default:             res_byte_next = 8'h00;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_action_reg <= cmd.res_action;
            res_byte_reg   <= res_byte_next;
            res_last_reg   <= (cmd.res_action == tle_pkg::ACT_READ) && status.held_one;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_action_reg <= res_action_reg;
            out_byte_reg   <= res_byte_reg;
            out_count_reg  <= (res_action_reg == tle_pkg::ACT_ERASE) ? 7'(n_reg) : 7'd0;
            out_last_reg   <= res_last_reg;
        end
    end

    always_comb
    begin
        status.kind = kind_reg;
        unique case (byte_reg)
            tle_pkg::CHR_CR:  status.cls = tle_pkg::CLS_CR;
            tle_pkg::CHR_BS,
            tle_pkg::CHR_DEL: status.cls = tle_pkg::CLS_ERASE1;
            tle_pkg::CHR_ETB: status.cls = tle_pkg::CLS_WERASE;
            tle_pkg::CHR_NAK: status.cls = tle_pkg::CLS_KILL;
            default:          status.cls = tle_pkg::CLS_OTHER;
        endcase
        status.ready     = ready_reg;
        status.held_zero = (held_reg == '0);
        status.held_one  = (held_reg == CW'(1));
        status.full      = (held_reg >= FULL_CNT);
        status.rd_white  = tle_pkg::is_white(rd_data_reg);
        status.n_zero    = (n_reg == '0);
        status.out_free  = !out_valid_reg || m_tready;
    end

    assign out_valid  = out_valid_reg;
    assign out_action = out_action_reg;
    assign out_byte   = out_byte_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

    a_ready_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (held_reg != '0))
        else $error("line ready with empty ring");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(RING_DEPTH))
        else $error("held count beyond ring depth");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output overwritten before transfer");

    a_ready_from_cr: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> ($past(cmd.op) == tle_pkg::DP_PUSH_NL))
        else $error("line ready without newline push");

endmodule

`default_nettype wire

### sv/tle_ctrl.sv
// Controller state machine of the line editor: decodes each item and
// sequences the datapath. Uses tle_pkg types and constants.
`default_nettype none

module tle_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  tle_pkg::dp_status_t  status,
    output tle_pkg::ctl_cmd_t    cmd
);

    tle_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tle_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tle_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = tle_pkg::ST_DECODE;
                end
            end
            tle_pkg::ST_DECODE:
            begin
                if (status.kind == tle_pkg::KIND_POP)
                begin
                    state_next = (!status.ready || status.held_zero) ?
                                 tle_pkg::ST_EMIT : tle_pkg::ST_POP;
                end
                else if (status.ready)
                begin
                    state_next = tle_pkg::ST_EMIT;
                end
                else
                begin
                    unique case (status.cls)
                        tle_pkg::CLS_WERASE:
                            state_next = status.held_zero ? tle_pkg::ST_IDLE
                                                          : tle_pkg::ST_WORD;
                        tle_pkg::CLS_KILL:
                            state_next = status.held_zero ? tle_pkg::ST_IDLE
                                                          : tle_pkg::ST_EMIT;
                        default:
                            state_next = tle_pkg::ST_EMIT;
                    endcase
                end
            end
            tle_pkg::ST_POP:
            begin
                state_next = tle_pkg::ST_EMIT;
            end
            tle_pkg::ST_WORD:
            begin
                priority if (!status.held_zero && !status.rd_white)
                begin
                    state_next = tle_pkg::ST_WORD;
                end
                else if (status.n_zero)
                begin
                    state_next = tle_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tle_pkg::ST_EMIT;
                end
            end
            tle_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = tle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tle_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd            = '0;
        cmd.op         = tle_pkg::DP_NONE;
        cmd.rd_sel     = tle_pkg::RD_HEAD;
        cmd.res_action = tle_pkg::ACT_EMPTY;
        s_tready       = 1'b0;
        unique case (state_reg)
            tle_pkg::ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            tle_pkg::ST_DECODE:
            begin
                if (status.kind == tle_pkg::KIND_POP)
                begin
                    if (!status.ready || status.held_zero)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_action = tle_pkg::ACT_EMPTY;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = tle_pkg::RD_HEAD;
                    end
                end
                else if (status.ready)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_action = tle_pkg::ACT_REJECT;
                end
                else
                begin
                    unique case (status.cls)
                        tle_pkg::CLS_CR:
                        begin
                            cmd.op         = tle_pkg::DP_PUSH_NL;
                            cmd.res_load   = 1'b1;
                            cmd.res_action = tle_pkg::ACT_NEWLINE;
                        end
                        tle_pkg::CLS_ERASE1:
                        begin
                            cmd.res_load = 1'b1;
                            if (status.held_zero)
                            begin
                                cmd.res_action = tle_pkg::ACT_BELL;
                            end
                            else
                            begin
                                cmd.op         = tle_pkg::DP_DROP;
                                cmd.res_action = tle_pkg::ACT_ERASE;
                            end
                        end
                        tle_pkg::CLS_WERASE:
                        begin
                            cmd.clr_n  = 1'b1;
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = tle_pkg::RD_TAIL_PREV;
                        end
                        tle_pkg::CLS_KILL:
                        begin
                            if (!status.held_zero)
                            begin
                                cmd.op         = tle_pkg::DP_CLEAR;
                                cmd.res_load   = 1'b1;
                                cmd.res_action = tle_pkg::ACT_ERASE;
                            end
                        end
                        default:
                        begin
                            cmd.res_load = 1'b1;
                            if (status.full)
                            begin
                                cmd.res_action = tle_pkg::ACT_BELL;
                            end
                            else
                            begin
                                cmd.op         = tle_pkg::DP_PUSH_BYTE;
                                cmd.res_action = tle_pkg::ACT_ECHO;
                            end
                        end
                    endcase
                end
            end
            tle_pkg::ST_POP:
            begin
                cmd.op         = tle_pkg::DP_POP;
                cmd.res_load   = 1'b1;
                cmd.res_action = tle_pkg::ACT_READ;
            end
            tle_pkg::ST_WORD:
            begin
                if (!status.held_zero && !status.rd_white)
                begin
                    // drop and fetch the next char back in the same cycle
                    cmd.op     = tle_pkg::DP_WORD_DROP;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = tle_pkg::RD_TAIL_PREV2;
                end
                else if (!status.n_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_action = tle_pkg::ACT_ERASE;
                end
            end
            tle_pkg::ST_EMIT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tle_pkg::ST_EMIT && !status.out_free) |=>
        (state_reg == tle_pkg::ST_EMIT))
        else $error("result dropped while output busy");

    a_pop_follows_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tle_pkg::ST_POP) |-> ($past(state_reg) == tle_pkg::ST_DECODE))
        else $error("pop entered out of sequence");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_in |=> (state_reg == tle_pkg::ST_DECODE))
        else $error("accepted item not decoded");

endmodule

`default_nettype wire

### sv/terminal_line_editor_core.sv
// Each item goes through decode, then emit; a line read adds a pop step, and a word erase
// stays in its word state while it drops chars. A Ctrl-W or Ctrl-U that erases nothing
// returns to idle with no result. One item is in flight at a time, and the one ring read
// port serves decode, pop and word erase.
// A result held off by m_tready keeps the next item in emit until the output register frees.
// Reset: rst_n async low clears indexes, counts, line-ready and output valid; ring not cleared.
// Top level of the terminal line editor; uses tle_pkg, tle_ctrl, tle_datapath.
`default_nettype none

module terminal_line_editor_core #(
    parameter int RING_DEPTH = 127   // ring entries, at most 128 (7-bit erase count)
) (
    input  wire         clk,
    input  wire         rst_n,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] rx_byte
    input  wire         s_tuser,    // [0] kind
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [14:8] erase_count, [15] zero
    output logic [2:0]  m_tuser,    // [2:0] action
    output logic        m_tlast     // line_last
);

    tle_pkg::ctl_cmd_t   cmd;
    tle_pkg::dp_status_t status;
    tle_pkg::action_t    out_action;
    logic [7:0]          out_byte;
    logic [6:0]          out_count;

    // controller: one item in flight; accepts while a result waits in the output reg
    tle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: ring, head/tail/count, word-erase counter, output register
    tle_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_kind    (s_tuser),
        .in_byte    (s_tdata),
        .m_tready   (m_tready),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_action (out_action),
        .out_byte   (out_byte),
        .out_count  (out_count),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, out_count, out_byte};
    assign m_tuser = out_action;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for terminal_line_editor_core (cooked-mode line editor).
// Depends on tle_pkg for the action codes, control characters and item kinds.
// Replies are predicted per accepted transfer and compared in arrival order.

module tb;

    localparam int RING           = 127;   // ring depth, same as the block default
    localparam int HOLD_LEN       = 200;   // long receiver hold-off, in cycles
    localparam int DRAIN_CYCLES   = 140;   // longer than the worst word erase (126 chars)
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either side
    localparam int PHASE_ITEMS    = 70;    // random items per handshake mix

    // One reply of the editor, as the terminal sees it
    typedef struct {
        tle_pkg::action_t action;
        logic [7:0]       out_byte;
        logic [6:0]       erase_count;
        logic             line_last;
    } terminal_reply_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // Block ports, all inputs known from time zero
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    terminal_line_editor_core #(
        .RING_DEPTH (RING)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Handshake mix, changed per test phase
    int idle_pct  = 0;     // sender idles this many cycles of a hundred
    int stall_pct = 0;     // receiver stalls this many cycles of a hundred

    // Long hold-off on the result side, armed once by the backpressure test
    logic hold_armed = 1'b0;
    int   hold_done  = 0;

    // Run bookkeeping
    int items_sent   = 0;
    int replies_seen = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    // Predicted editor state: ring contents, head/tail, held count, line ready
    logic [7:0] line_copy [RING];
    int         head_pos   = 0;
    int         tail_pos   = 0;
    int         held_n     = 0;
    logic       line_ready = 1'b0;

    terminal_reply_t terminal_replies_q [$];

    // Whitespace as the word erase sees it: space and TAB..CR
    function automatic logic is_blank(input logic [7:0] c);
        return (c == tle_pkg::CHR_SP) || (c >= tle_pkg::CHR_TAB && c <= tle_pkg::CHR_CR);
    endfunction

    // Advance the predicted editor by one accepted transfer and queue the
    // reply it causes. Ctrl-W / Ctrl-U that erase nothing queue no reply.
    function automatic void predict_terminal_reply(input logic kind, input logic [7:0] c);
        terminal_reply_t r;
        int              n;
        n             = 0;
        r.action      = tle_pkg::ACT_EMPTY;
        r.out_byte    = 8'h00;
        r.erase_count = 7'd0;
        r.line_last   = 1'b0;
        if (kind == tle_pkg::KIND_POP)
        begin
            // pop only from a completed line; otherwise an empty read
            if (line_ready && held_n != 0)
            begin
                r.action   = tle_pkg::ACT_READ;
                r.out_byte = line_copy[head_pos];
                head_pos   = (head_pos + 1) % RING;
                held_n--;
                if (held_n == 0)
                begin
                    line_ready  = 1'b0;
                    r.line_last = 1'b1;
                end
            end
        end
        else if (line_ready)
        begin
            r.action   = tle_pkg::ACT_REJECT;
            r.out_byte = c;
        end
        else if (c == tle_pkg::CHR_CR)
        begin
            line_copy[tail_pos] = tle_pkg::CHR_LF;
            tail_pos            = (tail_pos + 1) % RING;
            held_n++;
            line_ready          = 1'b1;
            r.action            = tle_pkg::ACT_NEWLINE;
        end
        else if (c == tle_pkg::CHR_BS || c == tle_pkg::CHR_DEL)
        begin
            if (held_n == 0)
            begin
                r.action   = tle_pkg::ACT_BELL;
                r.out_byte = tle_pkg::CHR_BEL;
            end
            else
            begin
                tail_pos      = (tail_pos + RING - 1) % RING;
                held_n--;
                r.action      = tle_pkg::ACT_ERASE;
                r.erase_count = 7'd1;
            end
        end
        else if (c == tle_pkg::CHR_ETB || c == tle_pkg::CHR_NAK)
        begin
            // word erase stops at whitespace before the cursor; kill takes all
            while (held_n > 0 &&
                   (c == tle_pkg::CHR_NAK ||
                    !is_blank(line_copy[(tail_pos + RING - 1) % RING])))
            begin
                tail_pos = (tail_pos + RING - 1) % RING;
                held_n--;
                n++;
            end
            if (n == 0)
                return;
            r.action      = tle_pkg::ACT_ERASE;
            r.erase_count = 7'(n);
        end
        else if (held_n >= RING - 1)
        begin
            // one slot stays free for the newline
            r.action   = tle_pkg::ACT_BELL;
            r.out_byte = tle_pkg::CHR_BEL;
        end
        else
        begin
            line_copy[tail_pos] = c;
            tail_pos            = (tail_pos + 1) % RING;
            held_n++;
            r.action            = tle_pkg::ACT_ECHO;
            r.out_byte          = c;
        end
        terminal_replies_q.push_back(r);
    endfunction

    // Offer one item after a random idle gap and hold it until the block
    // takes it. Valid stays high between back-to-back items.
    task automatic send_item(input logic kind, input logic [7:0] c);
        int gap;
        gap = 0;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_terminal_reply(kind, c);
        items_sent++;
    endtask

    // Result side: random stalls, or the one long hold-off when armed
    always @(posedge clk)
    begin
        if (hold_armed && hold_done < HOLD_LEN)
        begin
            m_tready  <= 1'b0;
            hold_done <= hold_done + 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Compare each reply transfer with the oldest prediction
    always @(posedge clk)
    begin : reply_check
        terminal_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            replies_seen++;
            if (terminal_replies_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected reply: action %0d data %h last %b",
                             $realtime, m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                want = terminal_replies_q.pop_front();
                if (m_tuser !== want.action ||
                    m_tdata !== {1'b0, want.erase_count, want.out_byte} ||
                    m_tlast !== want.line_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] reply mismatch: want action %0d byte %h erase %0d ",
                                  "last %b, got action %0d byte %h erase %0d last %b (tdata %h)"},
                                 $realtime, want.action, want.out_byte, want.erase_count,
                                 want.line_last, m_tuser, m_tdata[7:0], m_tdata[14:8],
                                 m_tlast, m_tdata);
                end
            end
        end
    end

    // Watchdog: too long with no transfer on either side ends the run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no transfer for %0d cycles, %0d replies pending",
                     $realtime, quiet_cycles, terminal_replies_q.size());
            $display("** terminal_line_editor_core: FAILED **");
            $finish;
        end
    end

    // One typed line with random content, then CR and read-back. Now and
    // then a lone random item instead, as noise.
    task automatic run_session();
        int         len;
        int         pick;
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
        begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            return;
        end
        len = $urandom_range(0, 18);
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 58)
                c = 8'($urandom_range(8'h21, 8'h7E));
            else if (pick < 72)
                c = ($urandom_range(0, 1) != 0) ? tle_pkg::CHR_SP :
                    8'($urandom_range(tle_pkg::CHR_TAB, 8'h0C));
            else if (pick < 82)
                c = ($urandom_range(0, 1) != 0) ? tle_pkg::CHR_BS : tle_pkg::CHR_DEL;
            else if (pick < 88)
                c = tle_pkg::CHR_ETB;
            else if (pick < 91)
                c = tle_pkg::CHR_NAK;
            else
                c = 8'($urandom_range(0, 255));
            // a few reads while the line is still being typed
            if (pick >= 98)
                send_item(tle_pkg::KIND_POP, c);
            else
                send_item(tle_pkg::KIND_EDIT, c);
        end
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_CR);
        if ($urandom_range(0, 3) == 0)
            send_item(tle_pkg::KIND_EDIT, 8'($urandom_range(0, 255)));
        while (line_ready)
            send_item(tle_pkg::KIND_POP, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0)
            send_item(tle_pkg::KIND_POP, 8'($urandom_range(0, 255)));
    endtask

    // Fresh out of reset: reads and erases on an empty line
    task automatic test_empty_line();
        send_item(tle_pkg::KIND_POP, 8'hFF);             // nothing ready: empty read
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_BS);  // bell
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_DEL); // bell
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_ETB); // nothing to erase, no reply
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_NAK); // nothing to erase, no reply
    endtask

    // Editing keys BS, Ctrl-W, Ctrl-U and CR, then a line read back with a byte rejected meanwhile
    task automatic test_edit_keys();
        send_item(tle_pkg::KIND_EDIT, 8'h00);    // extremes are ordinary characters
        send_item(tle_pkg::KIND_EDIT, 8'hFF);
        send_item(tle_pkg::KIND_EDIT, "a");
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_SP);
        send_item(tle_pkg::KIND_EDIT, "b");
        send_item(tle_pkg::KIND_EDIT, "c");
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_ETB);  // erases "bc"
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_ETB);  // space before cursor: no reply
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_BS);   // erases the space
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_NAK);  // erases the remaining three
        send_item(tle_pkg::KIND_EDIT, "x");
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_TAB);
        send_item(tle_pkg::KIND_EDIT, "y");
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_ETB);  // erases "y", stops at TAB
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_CR);
        send_item(tle_pkg::KIND_EDIT, 8'hFF);    // line ready: rejected
        send_item(tle_pkg::KIND_POP, 8'h00);     // "x"
        send_item(tle_pkg::KIND_POP, 8'h5A);     // TAB
        send_item(tle_pkg::KIND_POP, 8'hA5);     // LF, empties the line
        send_item(tle_pkg::KIND_POP, 8'h00);     // empty read
    endtask

    // Fill the line to capacity, hit the full bell, then one maximal word erase
    task automatic test_full_line();
        while (held_n < RING - 1)
            send_item(tle_pkg::KIND_EDIT, 8'($urandom_range(8'h21, 8'h7E)));
        send_item(tle_pkg::KIND_EDIT, 8'h00);
        send_item(tle_pkg::KIND_EDIT, 8'hFF);
        send_item(tle_pkg::KIND_EDIT, tle_pkg::CHR_ETB);
    endtask

    task automatic test_random_sessions(input int sender_idle, input int receiver_stall);
        int start;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        start     = items_sent;
        while (items_sent - start < PHASE_ITEMS)
            run_session();
    endtask

    // Receiver holds off while the sender keeps offering, so the block
    // backs up and drops s_tready
    task automatic test_receiver_backpressure();
        int start;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_armed = 1'b1;
        start      = items_sent;
        while (items_sent - start < 40)
            run_session();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_line();
        test_edit_keys();
        idle_pct  = 35;
        stall_pct = 35;
        test_full_line();
        test_random_sessions(0, 0);
        test_random_sessions(78, 0);
        test_random_sessions(0, 78);
        test_random_sessions(35, 35);
        test_receiver_backpressure();

        s_tvalid <= 1'b0;
        while (terminal_replies_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input transfers and %0d replies: empty-line keys, all edits,",
                 items_sent, replies_seen);
        $display("full-line bell, 126-char word erase, rejects, read-back, four mixes, hold-off.");
        if (mismatches == 0)
            $display("** terminal_line_editor_core: PASSED **");
        else
            $display("** terminal_line_editor_core: FAILED **");
        $finish;
    end

endmodule

### terminal_line_editor_core.f
sv/tle_pkg.sv
sv/tle_datapath.sv
sv/tle_ctrl.sv
sv/terminal_line_editor_core.sv
tb/sv/tb.sv
